// File: rtl/nsap_pkg.sv
package nsap_pkg;

  // Default graph size, used as the defaults of the top level parameters.
  localparam int DEF_NODES = 1024;
  localparam int DEF_ARCS  = 4096;

  // Payload field widths.
  localparam int REQ_W    = 2;
  localparam int INDEX_W  = 13;
  localparam int OFFSET_W = 13;
  localparam int NODE_W   = 11;
  localparam int LABEL_W  = 13;
  localparam int STATUS_W = 2;

  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(1024);

  // Request types.
  typedef enum logic [REQ_W-1:0] {
    REQ_OFFSET = 2'd0,
    REQ_ADJ    = 2'd1,
    REQ_PATH   = 2'd2
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    RES_FOUND  = 2'd0,
    RES_NO_ARC = 2'd1,
    RES_BAD    = 2'd2
  } res_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        accept;
    logic        rd_lo;
    logic        rd_hi;
    logic        scan_init;
    logic        scan_step;
    logic        emit;
    res_status_t emit_status;
  } nsap_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic nodes_good;
    logic in_range;
    logic pend_valid;
    logic pend_hit;
    logic label_zero;
    logic path_failed;
  } nsap_stat_t;

endpackage

// File: rtl/nsap_ctrl.sv
module nsap_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nsap_pkg::REQ_W-1:0]    req_type,
  input  logic                          path_start,
  input  nsap_pkg::nsap_stat_t          stat,
  output nsap_pkg::nsap_cmd_t           cmd,
  output logic                          busy
);
  import nsap_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_OFF_HI = 5'b00100,
    ST_INIT   = 5'b01000,
    ST_SCAN   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit_status = RES_FOUND;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (req_type == REQ_PATH && !path_start && !stat.path_failed) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!stat.nodes_good) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = RES_BAD;
          state_next      = ST_IDLE;
        end else begin
          cmd.rd_lo  = 1'b1;
          state_next = ST_OFF_HI;
        end
      end
      ST_OFF_HI: begin
        cmd.rd_hi  = 1'b1;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        // The slot read in the previous cycle is checked before anything later.
        if (stat.pend_hit) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = stat.label_zero ? RES_NO_ARC : RES_FOUND;
          state_next      = ST_IDLE;
        end else if (!stat.pend_valid && !stat.in_range) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = RES_NO_ARC;
          state_next      = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/nsap_datapath.sv
module nsap_datapath #(
  parameter int NODES = nsap_pkg::DEF_NODES,
  parameter int ARCS  = nsap_pkg::DEF_ARCS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  nsap_pkg::nsap_cmd_t              cmd,
  output nsap_pkg::nsap_stat_t             stat,
  input  logic                             cfg_valid,
  input  logic [nsap_pkg::NODE_W-1:0]      cfg_data,
  input  logic [nsap_pkg::REQ_W-1:0]       req_type,
  input  logic [nsap_pkg::INDEX_W-1:0]     table_index,
  input  logic [nsap_pkg::OFFSET_W-1:0]    row_offset,
  input  logic [nsap_pkg::NODE_W-1:0]      neighbor_node,
  input  logic [nsap_pkg::LABEL_W-1:0]     arc_label,
  input  logic [nsap_pkg::NODE_W-1:0]      path_node,
  input  logic                             path_start,
  output logic                             result_valid,
  output logic [nsap_pkg::LABEL_W-1:0]     arc_number,
  output logic [nsap_pkg::STATUS_W-1:0]    status
);
  import nsap_pkg::*;

  localparam int OFF_DEPTH = NODES + 1;
  localparam int OFF_AW    = $clog2(OFF_DEPTH);
  localparam int ADJ_AW    = $clog2(ARCS);
  localparam int ADJ_W     = NODE_W + LABEL_W;

  // Graph tables.
  logic [OFFSET_W-1:0] offset_mem [OFF_DEPTH];
  logic [ADJ_W-1:0]    adj_mem    [ARCS];

  logic [OFFSET_W-1:0] off_rdata;
  logic [ADJ_W-1:0]    adj_rdata;
  logic [OFF_AW-1:0]   off_raddr;

  // Path and scan registers.
  logic [NODE_W-1:0]   node_count;
  logic [NODE_W-1:0]   prev_node;
  logic [NODE_W-1:0]   cur_node;
  logic                path_failed;
  logic [OFFSET_W-1:0] row_lo;
  logic [OFFSET_W-1:0] row_hi;
  logic [OFFSET_W-1:0] slot;
  logic                pend_valid;

  logic                is_offset_load;
  logic                is_adj_load;
  logic                prev_good;
  logic                cur_good;
  logic [NODE_W-1:0]   rd_neighbor;
  logic [LABEL_W-1:0]  rd_label;

  assign is_offset_load = cmd.accept && req_type == REQ_OFFSET &&
                          32'(table_index) <= NODES;
  assign is_adj_load    = cmd.accept && req_type == REQ_ADJ &&
                          32'(table_index) < ARCS;

  // Offset table: loads write, the two row bounds are read one after the other.
  assign off_raddr = cmd.rd_hi ? OFF_AW'(prev_node) : OFF_AW'(prev_node - NODE_W'(1));

  always_ff @(posedge clk) begin
    if (is_offset_load) begin
      offset_mem[OFF_AW'(table_index)] <= row_offset;
    end
    if (cmd.rd_lo || cmd.rd_hi) begin
      off_rdata <= offset_mem[off_raddr];
    end
  end

  // Adjacency table: neighbor and label share one word, one slot read per cycle.
  always_ff @(posedge clk) begin
    if (is_adj_load) begin
      adj_mem[ADJ_AW'(table_index)] <= {neighbor_node, arc_label};
    end
    if (cmd.scan_step && slot != '0) begin
      adj_rdata <= adj_mem[ADJ_AW'(slot - OFFSET_W'(1))];
    end
  end

  assign rd_neighbor = adj_rdata[ADJ_W-1:LABEL_W];
  assign rd_label    = adj_rdata[LABEL_W-1:0];

  // Node range checks.
  assign prev_good = prev_node != '0 && prev_node <= node_count && 32'(prev_node) <= NODES;
  assign cur_good  = cur_node != '0 && cur_node <= node_count && 32'(cur_node) <= NODES;

  assign stat.nodes_good  = prev_good && cur_good;
  assign stat.in_range    = slot < row_hi && 32'(slot) <= ARCS;
  assign stat.pend_valid  = pend_valid;
  assign stat.pend_hit    = pend_valid && rd_neighbor == cur_node;
  assign stat.label_zero  = rd_label == '0;
  assign stat.path_failed = path_failed;

  // Configuration register; the write port is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  // Path state: start stores node, a found arc advances it, failure stops path.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_node   <= '0;
      path_failed <= 1'b0;
    end else if (cmd.accept && req_type == REQ_PATH && path_start) begin
      prev_node   <= path_node;
      path_failed <= 1'b0;
    end else if (cmd.emit) begin
      if (cmd.emit_status == RES_FOUND) begin
        prev_node <= cur_node;
      end else begin
        path_failed <= 1'b1;
      end
    end
  end

  // Current node and row scan.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_node <= path_node;
    end
    if (cmd.rd_hi) begin
      row_lo <= off_rdata;
    end
    if (cmd.scan_init) begin
      row_hi <= off_rdata;
      slot   <= row_lo;
    end else if (cmd.scan_step && stat.in_range) begin
      slot <= slot + OFFSET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      pend_valid <= stat.in_range && slot != '0;
    end else begin
      pend_valid <= 1'b0;
    end
  end

  // Result register: one cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status     <= cmd.emit_status;
      arc_number <= (cmd.emit_status == RES_FOUND) ? rd_label : '0;
    end
  end

endmodule

// File: rtl/node_sequence_to_arc_path.sv
// Converts a sequence of path nodes into arc labels over a graph loaded in
// compressed sparse row form. Offset loads, adjacency loads, path starts and
// nodes of a failed path are taken without leaving the idle state. A path
// node whose nodes are bad is rejected in the check state. Any other path
// node goes through the check, offset-high and init states, then scans its
// row until a slot matches or the row ends. The row bounds come from one
// offset table read port, and the row is scanned one slot per cycle through
// the adjacency table read port. Results appear on result_valid for exactly
// one cycle and the receiver cannot stall them; busy falls in the cycle the
// result is shown. node_count, written via cfg_valid, is always ready.
module node_sequence_to_arc_path #(
  parameter int NODES = nsap_pkg::DEF_NODES,
  parameter int ARCS  = nsap_pkg::DEF_ARCS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nsap_pkg::NODE_W-1:0]      cfg_data,
  input  logic [nsap_pkg::REQ_W-1:0]       req_type,
  input  logic [nsap_pkg::INDEX_W-1:0]     table_index,
  input  logic [nsap_pkg::OFFSET_W-1:0]    row_offset,
  input  logic [nsap_pkg::NODE_W-1:0]      neighbor_node,
  input  logic [nsap_pkg::LABEL_W-1:0]     arc_label,
  input  logic [nsap_pkg::NODE_W-1:0]      path_node,
  input  logic                             path_start,
  output logic                             result_valid,
  output logic [nsap_pkg::LABEL_W-1:0]     arc_number,
  output logic [nsap_pkg::STATUS_W-1:0]    status
);
  import nsap_pkg::*;

  nsap_cmd_t  cmd;
  nsap_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer for requests and the row scan.
  nsap_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .path_start (path_start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Tables, path state and result register.
  nsap_datapath #(
    .NODES (NODES),
    .ARCS  (ARCS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .table_index   (table_index),
    .row_offset    (row_offset),
    .neighbor_node (neighbor_node),
    .arc_label     (arc_label),
    .path_node     (path_node),
    .path_start    (path_start),
    .result_valid  (result_valid),
    .arc_number    (arc_number),
    .status        (status)
  );

endmodule
